// ===== src/gwlf_pkg.sv =====
// Shared types, constants and helper functions for the guide-wire line-follow controller.
package gwlf_pkg;

    // Number of route entries that the route word holds and that are used.
    localparam int unsigned ROUTE_LENGTH = 8;

    // Coil offsets removed from the raw readings.
    localparam logic [11:0] OFFSET_LEFT   = 12'd56;
    localparam logic [11:0] OFFSET_CENTER = 12'd24;
    localparam logic [11:0] OFFSET_RIGHT  = 12'd23;

    // Manual command watchdog.
    localparam logic [8:0] WATCHDOG_MS = 9'd250;
    localparam logic [8:0] AGE_MAX     = 9'd511;

    // Confirm counter ceiling.
    localparam logic [2:0] CONFIRM_MAX = 3'd7;

    // Hold times in milliseconds.
    localparam logic [6:0] HOLD_NONE      = 7'd0;
    localparam logic [6:0] HOLD_MANUAL    = 7'd5;
    localparam logic [6:0] HOLD_SEARCH    = 7'd10;
    localparam logic [6:0] HOLD_NUDGE     = 7'd2;
    localparam logic [6:0] HOLD_LOST      = 7'd50;
    localparam logic [6:0] HOLD_CROSS_FWD = 7'd60;
    localparam logic [6:0] HOLD_TURN      = 7'd120;
    localparam logic [6:0] HOLD_EXIT_LEFT = 7'd40;
    localparam logic [6:0] HOLD_EXIT_RGT  = 7'd70;
    localparam logic [6:0] HOLD_FOLLOW    = 7'd10;
    localparam logic [6:0] HOLD_SPIN      = 7'd4;
    localparam logic [6:0] HOLD_SOFT      = 7'd25;

    // Remote command codes.
    localparam logic [3:0] IR_TOGGLE = 4'b0101;
    localparam logic [3:0] IR_FWD    = 4'b0010;
    localparam logic [3:0] IR_LEFT   = 4'b0011;
    localparam logic [3:0] IR_RIGHT  = 4'b0100;
    localparam logic [3:0] IR_BACK   = 4'b1101;

    // Output queue depth.
    localparam int unsigned OQ_DEPTH = 4;
    localparam int unsigned OQ_AW    = $clog2(OQ_DEPTH);

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_CMD    = 2'd1,
        OP_TICK   = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        DRV_STOP   = 3'd0,
        DRV_FWD    = 3'd1,
        DRV_SPIN_L = 3'd2,
        DRV_SPIN_R = 3'd3,
        DRV_SOFT_L = 3'd4,
        DRV_SOFT_R = 3'd5,
        DRV_BACK   = 3'd6
    } t_drive;

    typedef enum logic [1:0] {
        ACT_FWD   = 2'd0,
        ACT_LEFT  = 2'd1,
        ACT_RIGHT = 2'd2,
        ACT_STOP  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        CFG_ROUTE_WORD     = 3'd0,
        CFG_TRACK_MIN      = 3'd1,
        CFG_BALANCE_WINDOW = 3'd2,
        CFG_HARD_TURN      = 3'd3,
        CFG_CROSS_CENTER   = 3'd4,
        CFG_CROSS_SIDE     = 3'd5,
        CFG_CONFIRM_NEEDED = 3'd6,
        CFG_REARM_SAMPLES  = 3'd7
    } t_cfg_idx;

    // Configuration register set.
    typedef struct packed {
        logic [15:0] route_word;
        logic [11:0] track_min;
        logic [11:0] balance_window;
        logic [11:0] hard_turn_margin;
        logic [11:0] cross_center_min;
        logic [11:0] cross_side_min;
        logic [2:0]  confirm_needed;
        logic [7:0]  rearm_samples;
    } t_cfg;

    // One result beat.
    typedef struct packed {
        t_drive     drive;
        logic [6:0] hold_ms;
        logic       auto_on;
        logic       last;
    } t_result;

    // Up to two results handed together from the step logic to the output queue.
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

    // Removes a coil offset, floored at zero.
    function automatic logic [11:0] less_offset(input logic [11:0] raw,
                                                input logic [11:0] off);
        return (raw > off) ? (raw - off) : 12'd0;
    endfunction

    // Builds a result beat.
    function automatic t_result make_res(input t_drive drive, input logic [6:0] hold,
                                         input logic auto_on, input logic last);
        t_result res;
        res.drive   = drive;
        res.hold_ms = hold;
        res.auto_on = auto_on;
        res.last    = last;
        return res;
    endfunction

endpackage

// ===== src/gwlf_cfg.sv =====
// Configuration register file of the guide-wire line-follow controller.
module gwlf_cfg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_valid,
    input  logic [2:0]      i_cfg_index,
    input  logic [15:0]     i_cfg_data,
    output gwlf_pkg::t_cfg  o_cfg
);

    gwlf_pkg::t_cfg r_cfg;
    gwlf_pkg::t_cfg n_cfg;

    // Decode the written register.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (gwlf_pkg::t_cfg_idx'(i_cfg_index))
                gwlf_pkg::CFG_ROUTE_WORD:     n_cfg.route_word       = i_cfg_data;
                gwlf_pkg::CFG_TRACK_MIN:      n_cfg.track_min        = i_cfg_data[11:0];
                gwlf_pkg::CFG_BALANCE_WINDOW: n_cfg.balance_window   = i_cfg_data[11:0];
                gwlf_pkg::CFG_HARD_TURN:      n_cfg.hard_turn_margin = i_cfg_data[11:0];
                gwlf_pkg::CFG_CROSS_CENTER:   n_cfg.cross_center_min = i_cfg_data[11:0];
                gwlf_pkg::CFG_CROSS_SIDE:     n_cfg.cross_side_min   = i_cfg_data[11:0];
                gwlf_pkg::CFG_CONFIRM_NEEDED: n_cfg.confirm_needed   = i_cfg_data[2:0];
                gwlf_pkg::CFG_REARM_SAMPLES:  n_cfg.rearm_samples    = i_cfg_data[7:0];
                default:                      n_cfg = r_cfg;
            endcase
        end
    end

    // Registers with their power-up values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.route_word       <= 16'd61593;
            r_cfg.track_min        <= 12'd70;
            r_cfg.balance_window   <= 12'd300;
            r_cfg.hard_turn_margin <= 12'd750;
            r_cfg.cross_center_min <= 12'd1500;
            r_cfg.cross_side_min   <= 12'd800;
            r_cfg.confirm_needed   <= 3'd2;
            r_cfg.rearm_samples    <= 8'd120;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/gwlf_step.sv =====
// Input register, controller state and per-item decision logic.
module gwlf_step (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  gwlf_pkg::t_cfg  i_cfg,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [1:0]      i_operation,
    input  logic [11:0]     i_left_raw,
    input  logic [11:0]     i_center_raw,
    input  logic [11:0]     i_right_raw,
    input  logic [3:0]      i_ir_code,
    input  logic            i_room,
    output gwlf_pkg::t_push o_push
);

    // Input register.
    logic        r_in_valid;
    logic [1:0]  r_op;
    logic [11:0] r_left;
    logic [11:0] r_center;
    logic [11:0] r_right;
    logic [3:0]  r_ir;

    // Controller state.
    logic       r_auto;
    logic       r_searching;
    logic [3:0] r_index;
    logic [7:0] r_rearm;
    logic [2:0] r_confirm;
    logic       r_recovering;
    logic [8:0] r_age;
    logic       r_armed;

    logic       n_auto;
    logic       n_searching;
    logic [3:0] n_index;
    logic [7:0] n_rearm;
    logic [2:0] n_confirm;
    logic       n_recovering;
    logic [8:0] n_age;
    logic       n_armed;

    logic       advance;

    // Results before the mode bit and the final-beat flag are attached.
    logic [1:0]       cnt;
    gwlf_pkg::t_drive drv0;
    gwlf_pkg::t_drive drv1;
    logic [6:0]       hold0;
    logic [6:0]       hold1;

    assign advance = r_in_valid & i_room;
    assign o_ready = ~r_in_valid | i_room;

    // Decision logic for the item in the input register.
    always_comb begin
        logic [11:0] l;
        logic [11:0] c;
        logic [11:0] r;
        logic        l_gt_r;
        logic [11:0] ad;
        logic [11:0] peak;
        logic        big;
        logic        suspect;
        logic [2:0]  conf_inc;
        logic [8:0]  age_inc;
        logic [1:0]  action;
        logic        do_steer;

        n_auto       = r_auto;
        n_searching  = r_searching;
        n_index      = r_index;
        n_rearm      = r_rearm;
        n_confirm    = r_confirm;
        n_recovering = r_recovering;
        n_age        = r_age;
        n_armed      = r_armed;
        cnt          = 2'd0;
        drv0         = gwlf_pkg::DRV_STOP;
        drv1         = gwlf_pkg::DRV_STOP;
        hold0        = gwlf_pkg::HOLD_NONE;
        hold1        = gwlf_pkg::HOLD_NONE;
        do_steer     = 1'b0;

        l       = gwlf_pkg::less_offset(r_left, gwlf_pkg::OFFSET_LEFT);
        c       = gwlf_pkg::less_offset(r_center, gwlf_pkg::OFFSET_CENTER);
        r       = gwlf_pkg::less_offset(r_right, gwlf_pkg::OFFSET_RIGHT);
        l_gt_r  = l > r;
        ad      = l_gt_r ? (l - r) : (r - l);
        peak    = l_gt_r ? l : r;
        big     = (ad > i_cfg.hard_turn_margin) && !r_recovering;
        suspect = (c >= i_cfg.cross_center_min) && (l >= i_cfg.cross_side_min)
                  && (r >= i_cfg.cross_side_min);
        conf_inc = (r_confirm < gwlf_pkg::CONFIRM_MAX) ? (r_confirm + 3'd1) : r_confirm;
        age_inc  = (r_age < gwlf_pkg::AGE_MAX) ? (r_age + 9'd1) : r_age;
        action   = i_cfg.route_word[{r_index[2:0], 1'b0} +: 2];

        case (gwlf_pkg::t_op'(r_op))
            gwlf_pkg::OP_SAMPLE: begin
                if (r_auto) begin
                    if (r_searching) begin
                        // Searching for the wire.
                        if (peak < i_cfg.track_min) begin
                            cnt   = 2'd2;
                            drv0  = gwlf_pkg::DRV_SPIN_L;
                            hold0 = gwlf_pkg::HOLD_SEARCH;
                            hold1 = gwlf_pkg::HOLD_SEARCH;
                        end else if (ad > i_cfg.balance_window) begin
                            cnt   = 2'd2;
                            drv0  = l_gt_r ? gwlf_pkg::DRV_SPIN_L : gwlf_pkg::DRV_SPIN_R;
                            hold0 = gwlf_pkg::HOLD_NUDGE;
                            hold1 = gwlf_pkg::HOLD_SEARCH;
                        end else begin
                            n_searching  = 1'b0;
                            n_recovering = 1'b0;
                        end
                    end else if (peak < i_cfg.track_min) begin
                        // Wire lost.
                        cnt   = 2'd1;
                        hold0 = gwlf_pkg::HOLD_LOST;
                    end else if (r_rearm != 8'd0) begin
                        n_rearm   = r_rearm - 8'd1;
                        n_confirm = 3'd0;
                        do_steer  = 1'b1;
                    end else if (suspect) begin
                        n_confirm = conf_inc;
                        if (conf_inc >= i_cfg.confirm_needed) begin
                            // Confirmed intersection: follow the route.
                            n_rearm   = i_cfg.rearm_samples;
                            n_confirm = 3'd0;
                            cnt       = 2'd1;
                            if (r_index >= 4'(gwlf_pkg::ROUTE_LENGTH)) begin
                                n_auto = 1'b0;
                            end else begin
                                n_index = r_index + 4'd1;
                                case (gwlf_pkg::t_action'(action))
                                    gwlf_pkg::ACT_FWD: begin
                                        drv0         = gwlf_pkg::DRV_FWD;
                                        hold0        = gwlf_pkg::HOLD_CROSS_FWD;
                                        n_recovering = 1'b0;
                                    end
                                    gwlf_pkg::ACT_LEFT: begin
                                        cnt          = 2'd2;
                                        drv0         = gwlf_pkg::DRV_SPIN_L;
                                        hold0        = gwlf_pkg::HOLD_TURN;
                                        drv1         = gwlf_pkg::DRV_FWD;
                                        hold1        = gwlf_pkg::HOLD_EXIT_LEFT;
                                        n_recovering = 1'b1;
                                    end
                                    gwlf_pkg::ACT_RIGHT: begin
                                        cnt          = 2'd2;
                                        drv0         = gwlf_pkg::DRV_SPIN_R;
                                        hold0        = gwlf_pkg::HOLD_TURN;
                                        drv1         = gwlf_pkg::DRV_FWD;
                                        hold1        = gwlf_pkg::HOLD_EXIT_RGT;
                                        n_recovering = 1'b1;
                                    end
                                    default: begin
                                        n_auto = 1'b0;
                                    end
                                endcase
                            end
                        end else begin
                            do_steer = 1'b1;
                        end
                    end else begin
                        n_confirm = 3'd0;
                        do_steer  = 1'b1;
                    end

                    // Ordinary steering along the wire.
                    if (do_steer) begin
                        cnt = 2'd1;
                        if (ad <= i_cfg.balance_window) begin
                            drv0         = gwlf_pkg::DRV_FWD;
                            hold0        = gwlf_pkg::HOLD_FOLLOW;
                            n_recovering = 1'b0;
                        end else if (l_gt_r) begin
                            drv0  = big ? gwlf_pkg::DRV_SPIN_L : gwlf_pkg::DRV_SOFT_L;
                            hold0 = big ? gwlf_pkg::HOLD_SPIN : gwlf_pkg::HOLD_SOFT;
                        end else begin
                            drv0  = big ? gwlf_pkg::DRV_SPIN_R : gwlf_pkg::DRV_SOFT_R;
                            hold0 = big ? gwlf_pkg::HOLD_SPIN : gwlf_pkg::HOLD_SOFT;
                        end
                    end
                end
            end
            gwlf_pkg::OP_CMD: begin
                // Every command restarts the watchdog.
                n_age   = 9'd0;
                n_armed = 1'b1;
                if (r_ir == gwlf_pkg::IR_TOGGLE) begin
                    n_auto = ~r_auto;
                    cnt    = 2'd1;
                    if (!r_auto) begin
                        n_searching  = 1'b1;
                        n_index      = 4'd0;
                        n_rearm      = 8'd0;
                        n_confirm    = 3'd0;
                        n_recovering = 1'b0;
                    end
                end else if (!r_auto) begin
                    cnt   = 2'd2;
                    hold0 = gwlf_pkg::HOLD_MANUAL;
                    case (r_ir)
                        gwlf_pkg::IR_FWD:   drv1 = gwlf_pkg::DRV_FWD;
                        gwlf_pkg::IR_LEFT:  drv1 = gwlf_pkg::DRV_SPIN_L;
                        gwlf_pkg::IR_RIGHT: drv1 = gwlf_pkg::DRV_SPIN_R;
                        gwlf_pkg::IR_BACK:  drv1 = gwlf_pkg::DRV_BACK;
                        default: begin
                            cnt   = 2'd1;
                            hold0 = gwlf_pkg::HOLD_NONE;
                        end
                    endcase
                end
            end
            gwlf_pkg::OP_TICK: begin
                // Manual command watchdog.
                if (r_armed) begin
                    n_age = age_inc;
                    if (!r_auto && (age_inc > gwlf_pkg::WATCHDOG_MS)) begin
                        n_armed = 1'b0;
                        cnt     = 2'd1;
                    end
                end
            end
            default: begin
                cnt = 2'd0;
            end
        endcase
    end

    // Attach the mode bit and the final-beat flag.
    always_comb begin
        o_push.count = advance ? cnt : 2'd0;
        o_push.res0  = gwlf_pkg::make_res(drv0, hold0, n_auto, cnt == 2'd1);
        o_push.res1  = gwlf_pkg::make_res(drv1, hold1, n_auto, 1'b1);
    end

    // Input register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    // Input payload.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_op     <= i_operation;
            r_left   <= i_left_raw;
            r_center <= i_center_raw;
            r_right  <= i_right_raw;
            r_ir     <= i_ir_code;
        end
    end

    // Controller state, updated when an item completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto       <= 1'b0;
            r_searching  <= 1'b1;
            r_index      <= 4'd0;
            r_rearm      <= 8'd0;
            r_confirm    <= 3'd0;
            r_recovering <= 1'b0;
            r_age        <= 9'd0;
            r_armed      <= 1'b0;
        end else if (advance) begin
            r_auto       <= n_auto;
            r_searching  <= n_searching;
            r_index      <= n_index;
            r_rearm      <= n_rearm;
            r_confirm    <= n_confirm;
            r_recovering <= n_recovering;
            r_age        <= n_age;
            r_armed      <= n_armed;
        end
    end

endmodule

// ===== src/gwlf_outq.sv =====
// Result queue taking up to two beats per cycle and releasing one per cycle while the reader is ready.
module gwlf_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gwlf_pkg::t_push   i_push,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_ready,
    output gwlf_pkg::t_result o_res
);

    gwlf_pkg::t_result            r_mem [gwlf_pkg::OQ_DEPTH];
    logic [gwlf_pkg::OQ_AW-1:0]   r_wr_ptr;
    logic [gwlf_pkg::OQ_AW-1:0]   r_rd_ptr;
    logic [gwlf_pkg::OQ_AW:0]     r_count;
    logic [gwlf_pkg::OQ_AW-1:0]   n_wr_ptr;
    logic [gwlf_pkg::OQ_AW-1:0]   n_rd_ptr;
    logic [gwlf_pkg::OQ_AW:0]     n_count;
    logic                         pop;

    // Room for a full pair of beats.
    assign o_room  = r_count <= (gwlf_pkg::OQ_AW+1)'(gwlf_pkg::OQ_DEPTH - 2);
    assign o_valid = r_count != '0;
    assign o_res   = r_mem[r_rd_ptr];
    assign pop     = o_valid & i_ready;

    // Pointer and fill arithmetic.
    always_comb begin
        n_wr_ptr = r_wr_ptr + gwlf_pkg::OQ_AW'(i_push.count);
        n_rd_ptr = r_rd_ptr + gwlf_pkg::OQ_AW'(pop);
        n_count  = r_count + (gwlf_pkg::OQ_AW+1)'(i_push.count)
                   - (gwlf_pkg::OQ_AW+1)'(pop);
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr_ptr + gwlf_pkg::OQ_AW'(1)] <= i_push.res1;
        end
    end

    // Control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== src/guidewire_line_follow_controller.sv =====
// Top level of the guide-wire line-follow controller.
// Each beat on the input channel is a sensor sample, a remote command or a millisecond
// tick; it is registered, decided combinationally from that register and gives zero, one or two
// result beats (drive code, hold time, mode, final flag) into a four-entry result queue. A new
// item can be taken every cycle while the queue holds two beats or fewer, so items with one
// result sustain one per cycle while the reader is ready, and items with two results are held
// back by the single read port of the result queue. Configuration writes are taken
// every cycle and must only be issued while the block is idle.
module guidewire_line_follow_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_operation,
    input  logic [11:0] i_left_raw,
    input  logic [11:0] i_center_raw,
    input  logic [11:0] i_right_raw,
    input  logic [3:0]  i_ir_code,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_drive,
    output logic [6:0]  o_hold_ms,
    output logic        o_auto_on,
    output logic        o_last
);

    gwlf_pkg::t_cfg    cfg;
    gwlf_pkg::t_push   push;
    gwlf_pkg::t_result res;
    logic              room;

    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    gwlf_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Decision stage.
    gwlf_step u_step (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_operation  (i_operation),
        .i_left_raw   (i_left_raw),
        .i_center_raw (i_center_raw),
        .i_right_raw  (i_right_raw),
        .i_ir_code    (i_ir_code),
        .i_room       (room),
        .o_push       (push)
    );

    // Result queue.
    gwlf_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (res)
    );

    assign o_drive   = res.drive;
    assign o_hold_ms = res.hold_ms;
    assign o_auto_on = res.auto_on;
    assign o_last    = res.last;

endmodule
